// ----- rtl/lcu_pkg.sv -----
// Shared constants, codes and helpers for the linked checkpoint undo stack.
// No dependencies; used by the top level linked_checkpoint_undo_stack.
package lcu_pkg;

  localparam int MAX_HELD    = 64;
  localparam int HASH_WORDS  = 4;
  localparam int CP_WORDS    = 1 + 4 * HASH_WORDS;
  localparam int OFF_BLOCK   = 1;
  localparam int OFF_PARENT  = 1 + HASH_WORDS;
  localparam int OFF_STATE   = 1 + 2 * HASH_WORDS;
  localparam int OFF_PAYLOAD = 1 + 3 * HASH_WORDS;

  localparam int WORD_W     = 64;
  localparam int STATUS_W   = 4;
  localparam int HORIZON_W  = 6;
  localparam int CFG_DATA_W = 6;
  localparam int CFG_IDX_W  = 1;

  localparam int SLOT_W    = $clog2(MAX_HELD);
  localparam int SLOTX_W   = SLOT_W + 1;
  localparam int HELD_W    = $clog2(MAX_HELD + 1);
  localparam int ASM_IDX_W = $clog2(CP_WORDS);
  localparam int CNT_W     = $clog2(CP_WORDS + 1);
  localparam int MEM_DEPTH = MAX_HELD * CP_WORDS;
  localparam int ADDR_W    = $clog2(MEM_DEPTH);

  typedef enum logic [STATUS_W-1:0] {
    ST_ACCEPTED       = 4'd0,
    ST_BAD_CONFIG     = 4'd1,
    ST_BAD_CHECKPOINT = 4'd2,
    ST_DUPLICATE      = 4'd3,
    ST_HEIGHT_GAP     = 4'd4,
    ST_PARENT_MISMATCH = 4'd5,
    ST_TIP_MISMATCH   = 4'd6,
    ST_REBUILD        = 4'd7,
    ST_FRAMING        = 4'd8
  } status_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_PARAMS_PRESENT = 1'b0,
    CFG_UNDO_HORIZON   = 1'b1
  } cfg_idx_e;

  typedef enum logic {
    OP_CONNECT    = 1'b0,
    OP_DISCONNECT = 1'b1
  } opcode_e;

  // ring wrap of a slot sum that stays below twice the ring size
  function automatic logic [SLOT_W-1:0] slot_wrap(input logic [SLOTX_W-1:0] s);
    logic [SLOTX_W-1:0] r;
    if (s >= SLOTX_W'(MAX_HELD)) begin
      r = s - SLOTX_W'(MAX_HELD);
    end else begin
      r = s;
    end
    return r[SLOT_W-1:0];
  endfunction

  function automatic logic [ADDR_W-1:0] slot_base(input logic [SLOT_W-1:0] slot);
    return ADDR_W'(slot) * ADDR_W'(CP_WORDS);
  endfunction

endpackage

// ----- rtl/lcu_ram.sv -----
// Generic single-port-write, single-port-read RAM with registered read data.
// No dependencies; holds the checkpoint ring of the undo stack.
module lcu_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 1024
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ----- rtl/linked_checkpoint_undo_stack.sv -----
// Top level of the linked checkpoint undo stack: word assembly, checks and ring control.
// Depends on lcu_pkg and lcu_ram.
//
// Input channel (in_valid_i / in_stall_o) carries one 64-bit word per item with an
// opcode and a last mark. A connect is 17 words (height, block, parent, state,
// payload hash), a disconnect the 4 words of the expected tip hash. Words are taken
// one per cycle while a sequence is collected; only the last word gives a result.
// After the last word the input stalls while the sequence is resolved: a check
//   state, then for a tip compare the tip words are read from the checkpoint ram
//   and compared as they return (4 words for parent link or tip hash, 17 for a same
//   height duplicate), then 17 words are written to push, then the output register
//   is loaded. Errors found in the check state go straight to loading the output.
// Output channel (out_valid_o / out_stall_i) is a registered result. A stalled
// result holds; the next sequence is collected meanwhile and only its resolution
// waits for the output register to free up.
// Configuration writes (cfg_we_i, cfg_index_i, cfg_wdata_i) take effect next cycle.
// Reset empties the stack and clears the configuration; the ram needs no clearing.
module linked_checkpoint_undo_stack (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                cfg_we_i,
  input  logic [lcu_pkg::CFG_IDX_W-1:0]       cfg_index_i,
  input  logic [lcu_pkg::CFG_DATA_W-1:0]      cfg_wdata_i,
  input  logic                                in_valid_i,
  output logic                                in_stall_o,
  input  logic                                opcode_i,
  input  logic [lcu_pkg::WORD_W-1:0]          data_word_i,
  input  logic                                last_word_i,
  output logic                                out_valid_o,
  input  logic                                out_stall_i,
  output logic [lcu_pkg::STATUS_W-1:0]        status_o,
  output logic [lcu_pkg::HELD_W-1:0]          retained_count_o,
  output logic                                tip_present_o,
  output logic [lcu_pkg::WORD_W-1:0]          tip_height_o
);

  typedef enum logic [2:0] {
    S_ACCEPT,
    S_CHECK,
    S_CMP,
    S_PUSH,
    S_DONE
  } state_e;

  typedef enum logic [1:0] {
    M_DUP,
    M_LINK,
    M_TIP
  } mode_e;

  localparam int AW = lcu_pkg::ASM_IDX_W;
  localparam int CW = lcu_pkg::CNT_W;
  localparam int HW = lcu_pkg::HELD_W;
  localparam int SW = lcu_pkg::SLOT_W;
  localparam int XW = lcu_pkg::SLOTX_W;
  localparam int DW = lcu_pkg::WORD_W;

  state_e                         state_q, state_d;
  mode_e                          mode_q, mode_d;
  logic [CW-1:0]                  cnt_q, cnt_d;
  logic                           seq_op_q, seq_op_d;
  logic                           fault_q, fault_d;
  logic                           blk_nz_q, blk_nz_d, par_nz_q, par_nz_d;
  logic                           st_nz_q, st_nz_d, pay_nz_q, pay_nz_d;
  logic [SW-1:0]                  oldest_q, oldest_d;
  logic [HW-1:0]                  held_q, held_d;
  logic                           params_q, params_d;
  logic [lcu_pkg::HORIZON_W-1:0]  horizon_q, horizon_d;
  logic [AW-1:0]                  idx_q, idx_d, end_q, end_d;
  logic                           issuing_q, issuing_d;
  logic                           cmp_vld_q, cmp_vld_d, cmp_last_q, cmp_last_d;
  logic [AW-1:0]                  cmp_aidx_q, cmp_aidx_d;
  logic                           eq_q, eq_d;
  logic [lcu_pkg::ADDR_W-1:0]     base_q, base_d;
  lcu_pkg::status_e               res_q, res_d;
  logic [DW-1:0]                  tip_h_q, tip_h_d;
  logic                           out_valid_q, out_valid_d;
  logic [lcu_pkg::STATUS_W-1:0]   out_status_q, out_status_d;
  logic [HW-1:0]                  out_held_q, out_held_d;
  logic                           out_tip_q, out_tip_d;
  logic [DW-1:0]                  out_tip_h_q, out_tip_h_d;

  logic [DW-1:0]                  asm_q [lcu_pkg::CP_WORDS];
  logic [DW-1:0]                  cp_h_q;

  logic                           in_acc, first, over, store, nz, frame_bad;
  logic                           seq_op_w, fault_w;
  logic                           blk_nz_w, par_nz_w, st_nz_w, pay_nz_w;
  logic                           in_blk, in_par, in_st, in_pay;
  logic [CW-1:0]                  expected, cnt_inc;
  logic [SW-1:0]                  tip_slot, new_slot;
  logic [AW-1:0]                  asm_ridx;
  logic [DW-1:0]                  asm_rd;
  logic                           eq_now, drop;
  logic                           mem_we, mem_re;
  logic [lcu_pkg::ADDR_W-1:0]     mem_addr;
  logic [DW-1:0]                  mem_rdata;

  // ---------------------------------------------------------------- word intake
  assign in_stall_o = (state_q != S_ACCEPT);
  assign in_acc     = in_valid_i && !in_stall_o;
  assign first      = (cnt_q == '0);
  assign seq_op_w   = first ? opcode_i : seq_op_q;
  assign expected   = (seq_op_w == lcu_pkg::OP_DISCONNECT) ? CW'(lcu_pkg::HASH_WORDS)
                                                            : CW'(lcu_pkg::CP_WORDS);
  assign over       = (cnt_q >= expected);
  assign store      = !over;
  assign fault_w    = fault_q || (!first && (opcode_i != seq_op_q)) || over;
  assign cnt_inc    = (&cnt_q) ? cnt_q : cnt_q + CW'(1);
  assign frame_bad  = fault_w || (cnt_inc != expected);
  assign nz         = (data_word_i != '0);

  assign in_blk = store && (cnt_q >= CW'(lcu_pkg::OFF_BLOCK))
                        && (cnt_q <  CW'(lcu_pkg::OFF_PARENT));
  assign in_par = store && (cnt_q >= CW'(lcu_pkg::OFF_PARENT))
                        && (cnt_q <  CW'(lcu_pkg::OFF_STATE));
  assign in_st  = store && (cnt_q >= CW'(lcu_pkg::OFF_STATE))
                        && (cnt_q <  CW'(lcu_pkg::OFF_PAYLOAD));
  assign in_pay = store && (cnt_q >= CW'(lcu_pkg::OFF_PAYLOAD))
                        && (cnt_q <  CW'(lcu_pkg::CP_WORDS));

  // nonzero tracking per hash, restarted at the first word of a sequence
  assign blk_nz_w = (!first && blk_nz_q) || (in_blk && nz);
  assign par_nz_w = (!first && par_nz_q) || (in_par && nz);
  assign st_nz_w  = (!first && st_nz_q)  || (in_st  && nz);
  assign pay_nz_w = (!first && pay_nz_q) || (in_pay && nz);

  // ---------------------------------------------------------------- ring helpers
  assign tip_slot = lcu_pkg::slot_wrap({1'b0, oldest_q} + XW'(held_q) - XW'(1));
  assign new_slot = lcu_pkg::slot_wrap({1'b0, oldest_q} + XW'(held_q));
  assign drop     = (32'(held_q) > 32'(horizon_q)) || (32'(held_q) >= lcu_pkg::MAX_HELD);

  assign asm_ridx = (state_q == S_PUSH) ? idx_q : cmp_aidx_q;
  assign asm_rd   = asm_q[asm_ridx];
  assign eq_now   = eq_q && (mem_rdata == asm_rd);

  // ---------------------------------------------------------------- configuration
  always_comb begin
    params_d  = params_q;
    horizon_d = horizon_q;
    if (cfg_we_i) begin
      unique case (lcu_pkg::cfg_idx_e'(cfg_index_i))
        lcu_pkg::CFG_PARAMS_PRESENT: params_d  = cfg_wdata_i[0];
        lcu_pkg::CFG_UNDO_HORIZON:   horizon_d = cfg_wdata_i[lcu_pkg::HORIZON_W-1:0];
      endcase
    end
  end

  // ---------------------------------------------------------------- control
  always_comb begin
    state_d      = state_q;
    mode_d       = mode_q;
    cnt_d        = cnt_q;
    seq_op_d     = seq_op_q;
    fault_d      = fault_q;
    blk_nz_d     = blk_nz_q;
    par_nz_d     = par_nz_q;
    st_nz_d      = st_nz_q;
    pay_nz_d     = pay_nz_q;
    oldest_d     = oldest_q;
    held_d       = held_q;
    idx_d        = idx_q;
    end_d        = end_q;
    issuing_d    = issuing_q;
    cmp_vld_d    = 1'b0;
    cmp_last_d   = cmp_last_q;
    cmp_aidx_d   = cmp_aidx_q;
    eq_d         = eq_q;
    base_d       = base_q;
    res_d        = res_q;
    tip_h_d      = tip_h_q;
    out_valid_d  = out_valid_q && out_stall_i;
    out_status_d = out_status_q;
    out_held_d   = out_held_q;
    out_tip_d    = out_tip_q;
    out_tip_h_d  = out_tip_h_q;
    mem_we       = 1'b0;
    mem_re       = 1'b0;
    mem_addr     = base_q + lcu_pkg::ADDR_W'(idx_q);

    unique case (state_q)
      S_ACCEPT: begin
        if (in_acc) begin
          seq_op_d = seq_op_w;
          blk_nz_d = blk_nz_w;
          par_nz_d = par_nz_w;
          st_nz_d  = st_nz_w;
          pay_nz_d = pay_nz_w;
          if (last_word_i) begin
            cnt_d   = '0;
            fault_d = 1'b0;
            if (frame_bad) begin
              res_d   = lcu_pkg::ST_FRAMING;
              state_d = S_DONE;
            end else begin
              state_d = S_CHECK;
            end
          end else begin
            cnt_d   = cnt_inc;
            fault_d = fault_w;
          end
        end
      end

      S_CHECK: begin
        state_d   = S_DONE;
        base_d    = lcu_pkg::slot_base(tip_slot);
        eq_d      = 1'b1;
        issuing_d = 1'b1;
        idx_d     = AW'(lcu_pkg::OFF_BLOCK);
        end_d     = AW'(lcu_pkg::OFF_BLOCK + lcu_pkg::HASH_WORDS - 1);
        if (seq_op_q == lcu_pkg::OP_CONNECT) begin
          if (!params_q || (horizon_q == '0)) begin
            res_d = lcu_pkg::ST_BAD_CONFIG;
          end else if (!blk_nz_q || !st_nz_q || !pay_nz_q
                       || ((cp_h_q != '0) && !par_nz_q)) begin
            res_d = lcu_pkg::ST_BAD_CHECKPOINT;
          end else if (held_q == '0) begin
            if (cp_h_q != '0) begin
              res_d = lcu_pkg::ST_HEIGHT_GAP;
            end else begin
              base_d  = lcu_pkg::slot_base(new_slot);
              idx_d   = '0;
              state_d = S_PUSH;
            end
          end else if (cp_h_q == tip_h_q) begin
            // same height: whole checkpoint must match the tip
            mode_d  = M_DUP;
            idx_d   = '0;
            end_d   = AW'(lcu_pkg::CP_WORDS - 1);
            state_d = S_CMP;
          end else if ((&tip_h_q) || (cp_h_q != tip_h_q + DW'(1))) begin
            res_d = lcu_pkg::ST_HEIGHT_GAP;
          end else begin
            mode_d  = M_LINK;
            state_d = S_CMP;
          end
        end else begin
          if (held_q == '0) begin
            res_d = lcu_pkg::ST_TIP_MISMATCH;
          end else begin
            mode_d  = M_TIP;
            state_d = S_CMP;
          end
        end
      end

      S_CMP: begin
        // tip words stream from the ram, one compare per returned word
        cmp_vld_d = issuing_q;
        if (issuing_q) begin
          mem_re     = 1'b1;
          cmp_last_d = (idx_q == end_q);
          unique case (mode_q)
            M_DUP:  cmp_aidx_d = idx_q;
            M_LINK: cmp_aidx_d = idx_q + AW'(lcu_pkg::OFF_PARENT - lcu_pkg::OFF_BLOCK);
            M_TIP:  cmp_aidx_d = idx_q - AW'(lcu_pkg::OFF_BLOCK);
          endcase
          if (idx_q == end_q) begin
            issuing_d = 1'b0;
          end else begin
            idx_d = idx_q + AW'(1);
          end
        end
        if (cmp_vld_q) begin
          eq_d = eq_now;
          if (cmp_last_q) begin
            state_d = S_DONE;
            unique case (mode_q)
              M_DUP: begin
                res_d = eq_now ? lcu_pkg::ST_ACCEPTED : lcu_pkg::ST_DUPLICATE;
              end
              M_LINK: begin
                if (eq_now) begin
                  base_d  = lcu_pkg::slot_base(new_slot);
                  idx_d   = '0;
                  state_d = S_PUSH;
                end else begin
                  res_d = lcu_pkg::ST_PARENT_MISMATCH;
                end
              end
              M_TIP: begin
                if (!eq_now) begin
                  res_d = lcu_pkg::ST_TIP_MISMATCH;
                end else if (held_q <= HW'(1)) begin
                  res_d = lcu_pkg::ST_REBUILD;
                end else begin
                  held_d  = held_q - HW'(1);
                  tip_h_d = tip_h_q - DW'(1);
                  res_d   = lcu_pkg::ST_ACCEPTED;
                end
              end
            endcase
          end
        end
      end

      S_PUSH: begin
        mem_we = 1'b1;
        if (idx_q == AW'(lcu_pkg::CP_WORDS - 1)) begin
          if (drop) begin
            oldest_d = lcu_pkg::slot_wrap({1'b0, oldest_q} + XW'(1));
          end else begin
            held_d = held_q + HW'(1);
          end
          tip_h_d = cp_h_q;
          res_d   = lcu_pkg::ST_ACCEPTED;
          state_d = S_DONE;
        end else begin
          idx_d = idx_q + AW'(1);
        end
      end

      S_DONE: begin
        if (!out_valid_q || !out_stall_i) begin
          out_valid_d  = 1'b1;
          out_status_d = res_q;
          out_held_d   = held_q;
          out_tip_d    = (held_q != '0);
          out_tip_h_d  = (held_q != '0) ? tip_h_q : '0;
          state_d      = S_ACCEPT;
        end
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= S_ACCEPT;
      mode_q       <= M_DUP;
      cnt_q        <= '0;
      seq_op_q     <= 1'b0;
      fault_q      <= 1'b0;
      blk_nz_q     <= 1'b0;
      par_nz_q     <= 1'b0;
      st_nz_q      <= 1'b0;
      pay_nz_q     <= 1'b0;
      oldest_q     <= '0;
      held_q       <= '0;
      params_q     <= 1'b0;
      horizon_q    <= '0;
      idx_q        <= '0;
      end_q        <= '0;
      issuing_q    <= 1'b0;
      cmp_vld_q    <= 1'b0;
      cmp_last_q   <= 1'b0;
      cmp_aidx_q   <= '0;
      eq_q         <= 1'b0;
      base_q       <= '0;
      res_q        <= lcu_pkg::ST_ACCEPTED;
      tip_h_q      <= '0;
      out_valid_q  <= 1'b0;
      out_status_q <= '0;
      out_held_q   <= '0;
      out_tip_q    <= 1'b0;
      out_tip_h_q  <= '0;
    end else begin
      state_q      <= state_d;
      mode_q       <= mode_d;
      cnt_q        <= cnt_d;
      seq_op_q     <= seq_op_d;
      fault_q      <= fault_d;
      blk_nz_q     <= blk_nz_d;
      par_nz_q     <= par_nz_d;
      st_nz_q      <= st_nz_d;
      pay_nz_q     <= pay_nz_d;
      oldest_q     <= oldest_d;
      held_q       <= held_d;
      params_q     <= params_d;
      horizon_q    <= horizon_d;
      idx_q        <= idx_d;
      end_q        <= end_d;
      issuing_q    <= issuing_d;
      cmp_vld_q    <= cmp_vld_d;
      cmp_last_q   <= cmp_last_d;
      cmp_aidx_q   <= cmp_aidx_d;
      eq_q         <= eq_d;
      base_q       <= base_d;
      res_q        <= res_d;
      tip_h_q      <= tip_h_d;
      out_valid_q  <= out_valid_d;
      out_status_q <= out_status_d;
      out_held_q   <= out_held_d;
      out_tip_q    <= out_tip_d;
      out_tip_h_q  <= out_tip_h_d;
    end
  end

  // assembly buffer for every stored word; the height word is also kept in cp_h_q
  always_ff @(posedge clk_i) begin
    if (in_acc && store) begin
      asm_q[cnt_q[AW-1:0]] <= data_word_i;
      if (first) begin
        cp_h_q <= data_word_i;
      end
    end
  end

  lcu_ram #(
    .WIDTH (DW),
    .DEPTH (lcu_pkg::MEM_DEPTH)
  ) u_store (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (mem_addr),
    .wdata_i (asm_rd),
    .re_i    (mem_re),
    .raddr_i (mem_addr),
    .rdata_o (mem_rdata)
  );

  assign out_valid_o      = out_valid_q;
  assign status_o         = out_status_q;
  assign retained_count_o = out_held_q;
  assign tip_present_o    = out_tip_q;
  assign tip_height_o     = out_tip_h_q;

  // ---------------------------------------------------------------- assertions
  a_held_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    32'(held_q) <= lcu_pkg::MAX_HELD)
    else $error("held count beyond ring size");

  a_never_empties: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (held_q != '0) |=> (held_q != '0))
    else $error("stack emptied after holding a checkpoint");

  a_addr_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (mem_we || mem_re) |-> (32'(mem_addr) < lcu_pkg::MEM_DEPTH))
    else $error("ram address outside the ring");

  a_seq_closed: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q != S_ACCEPT) |-> ((cnt_q == '0) && !fault_q))
    else $error("word sequence left open while resolving");

  a_cmp_in_state: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmp_vld_q |-> (state_q == S_CMP))
    else $error("tip word returned outside compare phase");

endmodule
